// ===== src/abt_pkg.sv =====
// Shared types and constants for the alarm blink timer.
package abt_pkg;

    localparam int CNT_W = 24;

    localparam logic [15:0] TPS_RESET = 16'd1000;

    // Function field of an input transaction
    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Device function type accepted by the alarm
    localparam logic [7:0] FTYPE_ALARM = 8'h01;

    // Alarm commands
    localparam logic [7:0] CMD_STOP  = 8'h00;
    localparam logic [7:0] CMD_START = 8'h01;

    // Result codes
    localparam logic RC_OK     = 1'b0;
    localparam logic RC_REJECT = 1'b1;

    // Register word index (paddr[2])
    localparam logic REG_TPS = 1'b0;

    typedef struct packed {
        logic       func;
        logic [7:0] func_type;
        logic [7:0] alarm_cmd;
        logic [7:0] blink_half_period;
        logic [7:0] hold_time;
    } t_in_item;

    typedef struct packed {
        logic       result_code;
        logic       alarm_out;
        logic       alarm_running;
        logic [7:0] stored_mode;
        logic [7:0] stored_hold;
    } t_out_item;

endpackage

// ===== src/abt_in_if.sv =====
// Input stream interface: commands and timer ticks.
interface abt_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] func_type;
    logic [7:0] alarm_cmd;
    logic [7:0] blink_half_period;
    logic [7:0] hold_time;

    modport source (output valid, output func, output func_type, output alarm_cmd,
                    output blink_half_period, output hold_time, input ready);
    modport sink   (input valid, input func, input func_type, input alarm_cmd,
                    input blink_half_period, input hold_time, output ready);
endinterface

// ===== src/abt_out_if.sv =====
// Output stream interface: one status result per input transaction.
interface abt_out_if;
    logic       valid;
    logic       ready;
    logic       result_code;
    logic       alarm_out;
    logic       alarm_running;
    logic [7:0] stored_mode;
    logic [7:0] stored_hold;

    modport source (output valid, output result_code, output alarm_out,
                    output alarm_running, output stored_mode, output stored_hold,
                    input ready);
    modport sink   (input valid, input result_code, input alarm_out,
                    input alarm_running, input stored_mode, input stored_hold,
                    output ready);
endinterface

// ===== src/alarm_blink_timer_top.sv =====
// Alarm blink timer top level: command/tick decode, countdowns and output register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------------
//  i_cmd    | in  | valid/ready        | func, func_type, alarm_cmd, blink_half_period,
//           |     |                    | hold_time
//  o_res    | out | valid/ready        | result_code, alarm_out, alarm_running,
//           |     |                    | stored_mode, stored_hold
//  APB      | in  | psel/penable/pready| ticks_per_second at byte address 0
//
// One transaction per cycle sustained while o_res is not stalled. Each one passes the
// input register, then the state update into the result register. The state update
// is one 8x16 multiply per countdown reload plus a 24-bit decrement and zero compare.
// Reset (i_rst_n low, synchronous) stops the alarm, clears both stages and loads
// ticks_per_second with 1000. A stalled result holds in the result register while
// the input register still takes one more transaction.
module alarm_blink_timer_top
    import abt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    abt_in_if.sink      i_cmd,
    abt_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration
    logic [15:0] r_tps;

    // Pipeline
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_adv;

    // Alarm state
    logic             r_level,    n_level;
    logic             r_active,   n_active;
    logic             r_hold_en,  n_hold_en;
    logic             r_blink_en, n_blink_en;
    logic [CNT_W-1:0] r_hold_rem, n_hold_rem;
    logic [CNT_W-1:0] r_tog_rem,  n_tog_rem;
    logic [7:0]       r_mode,     n_mode;
    logic [7:0]       r_hold,     n_hold;
    logic             n_rc;

    logic [7:0]       w_mode_sel;
    logic [CNT_W-1:0] w_mode_span;
    logic [CNT_W-1:0] w_hold_span;
    logic [CNT_W-1:0] w_hold_dec;
    logic [CNT_W-1:0] w_tog_dec;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TPS) ? {16'd0, r_tps} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TPS) begin
            r_tps <= pwdata[15:0];
        end
    end

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.func              <= i_cmd.func;
            r_in.func_type         <= i_cmd.func_type;
            r_in.alarm_cmd         <= i_cmd.alarm_cmd;
            r_in.blink_half_period <= i_cmd.blink_half_period;
            r_in.hold_time         <= i_cmd.hold_time;
        end
    end

    // A start command reloads from its own mode; a tick reloads from the stored one
    assign w_mode_sel  = (r_in.func == FUNC_TICK) ? r_mode : r_in.blink_half_period;
    assign w_mode_span = {16'd0, w_mode_sel} * {8'd0, r_tps};
    assign w_hold_span = {16'd0, r_in.hold_time} * {8'd0, r_tps};
    assign w_hold_dec  = r_hold_rem - CNT_W'(r_hold_rem != '0);
    assign w_tog_dec   = r_tog_rem - CNT_W'(r_tog_rem != '0);

    always_comb begin
        n_level    = r_level;
        n_active   = r_active;
        n_hold_en  = r_hold_en;
        n_blink_en = r_blink_en;
        n_hold_rem = r_hold_rem;
        n_tog_rem  = r_tog_rem;
        n_mode     = r_mode;
        n_hold     = r_hold;
        n_rc       = RC_OK;
        if (r_in.func == FUNC_CMD) begin
            if (r_in.func_type != FTYPE_ALARM ||
                (r_in.alarm_cmd != CMD_STOP && r_in.alarm_cmd != CMD_START)) begin
                n_rc = RC_REJECT;
            end else if (r_in.alarm_cmd == CMD_STOP) begin
                n_mode     = r_in.blink_half_period;
                n_hold     = r_in.hold_time;
                n_level    = 1'b0;
                n_active   = 1'b0;
                n_hold_en  = 1'b0;
                n_blink_en = 1'b0;
            end else begin
                n_mode     = r_in.blink_half_period;
                n_hold     = r_in.hold_time;
                n_active   = 1'b1;
                n_level    = 1'b1;
                n_blink_en = (r_in.blink_half_period != 8'd0);
                n_hold_en  = (r_in.hold_time != 8'd0);
                n_tog_rem  = n_blink_en ? w_mode_span : '0;
                n_hold_rem = n_hold_en ? w_hold_span : '0;
            end
        end else begin
            // Hold expiry wins over a toggle on the same tick
            if (r_active && r_hold_en) begin
                n_hold_rem = w_hold_dec;
            end
            if (r_active && r_hold_en && w_hold_dec == '0) begin
                n_level    = 1'b0;
                n_active   = 1'b0;
                n_hold_en  = 1'b0;
                n_blink_en = 1'b0;
            end else if (r_active && r_blink_en) begin
                if (w_tog_dec == '0) begin
                    n_level   = !r_level;
                    n_tog_rem = w_mode_span;
                end else begin
                    n_tog_rem = w_tog_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= 1'b0;
            r_active   <= 1'b0;
            r_hold_en  <= 1'b0;
            r_blink_en <= 1'b0;
            r_hold_rem <= '0;
            r_tog_rem  <= '0;
            r_mode     <= 8'd0;
            r_hold     <= 8'd0;
        end else if (w_adv) begin
            r_level    <= n_level;
            r_active   <= n_active;
            r_hold_en  <= n_hold_en;
            r_blink_en <= n_blink_en;
            r_hold_rem <= n_hold_rem;
            r_tog_rem  <= n_tog_rem;
            r_mode     <= n_mode;
            r_hold     <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.result_code   <= n_rc;
            r_out.alarm_out     <= n_level;
            r_out.alarm_running <= n_active;
            r_out.stored_mode   <= n_mode;
            r_out.stored_hold   <= n_hold;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_code   = r_out.result_code;
    assign o_res.alarm_out     = r_out.alarm_out;
    assign o_res.alarm_running = r_out.alarm_running;
    assign o_res.stored_mode   = r_out.stored_mode;
    assign o_res.stored_hold   = r_out.stored_hold;

endmodule

// ===== src/abt_checker.sv =====
// Port-level assertions for the alarm blink timer, bound to the top level.
module abt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_result_code,
    input logic        i_alarm_out,
    input logic        i_alarm_running,
    input logic [7:0]  i_stored_mode,
    input logic [7:0]  i_stored_hold,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [2:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] i_prdata
);

    // Output level can only be high while the alarm runs
    a_level_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_alarm_out || i_alarm_running))
        else $error("alarm_out high while alarm stopped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_result_code) && $stable(i_alarm_out) &&
             $stable(i_alarm_running) && $stable(i_stored_mode) &&
             $stable(i_stored_hold)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Rate register reads back what was last written
    a_tps_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && !i_paddr[2]) |=>
            (i_paddr[2] || (i_prdata == {16'd0, $past(i_pwdata[15:0])})))
        else $error("ticks_per_second readback mismatch");

endmodule

bind alarm_blink_timer_top abt_checker u_abt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_result_code   (o_res.result_code),
    .i_alarm_out     (o_res.alarm_out),
    .i_alarm_running (o_res.alarm_running),
    .i_stored_mode   (o_res.stored_mode),
    .i_stored_hold   (o_res.stored_hold),
    .i_psel          (psel),
    .i_penable       (penable),
    .i_pwrite        (pwrite),
    .i_paddr         (paddr),
    .i_pwdata        (pwdata),
    .i_prdata        (prdata)
);
